// ===== rtl/utfd_pkg.sv =====
// shared types and constants of the utf-8 to ucs-2 decoder
package utfd_pkg;

   localparam logic [7:0]  LEAD2_MASK  = 8'hE0;
   localparam logic [7:0]  LEAD2_CODE  = 8'hC0;
   localparam logic [7:0]  LEAD3_MASK  = 8'hF0;
   localparam logic [7:0]  LEAD3_CODE  = 8'hE0;
   localparam logic [7:0]  ASCII_LIMIT = 8'h80;
   localparam logic [15:0] QMARK_UNIT  = 16'h003F;
   localparam logic [1:0]  SKIP_COUNT  = 2'd3;

   // one decoded result as handed from the decode stage to the result register
   typedef struct packed {
      logic        emit;
      logic [15:0] code_unit;
      logic        end_of_string;
   } result_type;

endpackage

// ===== rtl/utfd_core.sv =====
// decode logic and sequence state of the utf-8 to ucs-2 decoder
module utfd_core
   import utfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] data_byte,
   input  logic       fire,
   output result_type result
);

   logic [1:0]  bytes_pending_ff, bytes_pending_in;
   logic        skipping_ff, skipping_in;
   logic [15:0] partial_ff, partial_in;
   logic [1:0]  pending_dec;
   logic [15:0] partial_shift;

   assign pending_dec   = bytes_pending_ff - 2'd1;
   assign partial_shift = {partial_ff[9:0], data_byte[5:0]};

   always_comb begin
      bytes_pending_in     = bytes_pending_ff;
      skipping_in          = skipping_ff;
      partial_in           = partial_ff;
      result.emit          = 1'b0;
      result.code_unit     = 16'h0000;
      result.end_of_string = 1'b0;
      if (bytes_pending_ff != 2'd0) begin
         bytes_pending_in = pending_dec;
         if (skipping_ff) begin
            if (pending_dec == 2'd0) begin
               skipping_in = 1'b0;
            end
         end else begin
            partial_in = partial_shift;
            if (pending_dec == 2'd0) begin
               result.emit      = 1'b1;
               result.code_unit = partial_shift;
            end
         end
      end else begin
         skipping_in = 1'b0;
         if (data_byte == 8'h00) begin
            result.emit          = 1'b1;
            result.end_of_string = 1'b1;
         end else if (data_byte < ASCII_LIMIT) begin
            result.emit      = 1'b1;
            result.code_unit = {8'h00, data_byte};
         end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
            partial_in       = {11'd0, data_byte[4:0]};
            bytes_pending_in = 2'd1;
         end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
            partial_in       = {12'd0, data_byte[3:0]};
            bytes_pending_in = 2'd2;
         end else begin
            // unsupported lead: answer at once, then drop three bytes
            bytes_pending_in = SKIP_COUNT;
            skipping_in      = 1'b1;
            result.emit      = 1'b1;
            result.code_unit = QMARK_UNIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_pending_ff <= 2'd0;
         skipping_ff      <= 1'b0;
         partial_ff       <= 16'h0000;
      end else if (fire) begin
         bytes_pending_ff <= bytes_pending_in;
         skipping_ff      <= skipping_in;
         partial_ff       <= partial_in;
      end
   end

   a_skip_needs_pending: assert property (@(posedge clock) disable iff (reset)
      skipping_ff |-> bytes_pending_ff != 2'd0)
      else $error("skipping set with no bytes pending");

   a_end_only_at_start: assert property (@(posedge clock) disable iff (reset)
      result.end_of_string |-> bytes_pending_ff == 2'd0 && result.code_unit == 16'h0000)
      else $error("end of string outside a sequence start");

   a_lead2_pending: assert property (@(posedge clock) disable iff (reset)
      fire && bytes_pending_ff == 2'd0 && data_byte[7:5] == 3'b110
      |=> bytes_pending_ff == 2'd1 && !skipping_ff)
      else $error("two-byte lead did not arm one continuation");

   a_qmark_arms_skip: assert property (@(posedge clock) disable iff (reset)
      fire && result.emit && result.code_unit == QMARK_UNIT && data_byte[7]
      && bytes_pending_ff == 2'd0 |=> skipping_ff && bytes_pending_ff == SKIP_COUNT)
      else $error("unsupported lead did not start skipping");

endmodule

// ===== rtl/utf8_to_ucs2_decoder_unit.sv =====
// Streaming UTF-8 to UCS-2 decoder: one byte per req item, zero or one 16-bit
// code unit per rsp item. Items are taken one per cycle without gaps unless a
// stalled rsp side holds them; a byte is held in an input register, decoded
// against the sequence state and the result lands in the output register. The
// output register lets the next byte enter while a result still waits; a stalled
// rsp side blocks req only when both the input and output registers are full. A
// zero byte at a sequence start gives code unit 0 with rsp_end_of_string set;
// unsupported leads give 0x003F and the next three bytes are dropped.
module utf8_to_ucs2_decoder_unit
   import utfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_end_of_string
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_code_unit_ff;
   logic        rsp_end_ff;
   logic        out_free;
   logic        advance;
   result_type  result;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // an item with no result may always move on
   assign advance   = in_valid_ff && (!result.emit || out_free);
   assign req_ready = !in_valid_ff || advance;

   utfd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .data_byte (in_byte_ff),
      .fire      (advance),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.emit && out_free) begin
         rsp_code_unit_ff <= result.code_unit;
         rsp_end_ff       <= result.end_of_string;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_code_unit     = rsp_code_unit_ff;
   assign rsp_end_of_string = rsp_end_ff;

endmodule
